// ----- rtl/core/dfsd_pkg.sv -----
package dfsd_pkg;

  localparam int SIZE_BITS_DEF = 24;
  localparam logic [3:0] TYPE_RESET = 4'd8;

  // option nibble codes
  localparam logic [3:0] OPT_NARROW = 4'd0;
  localparam logic [3:0] OPT_WIDE = 4'd1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_EMPTY,
    ST_TYPE,
    ST_OPTION
  } status_t;

  typedef struct packed {
    logic       valid;
    logic       start;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   left_zero;
  } core_mon_t;

endpackage

// ----- rtl/core/delta_filter_stream_decoder.sv -----
// Delta-filter stream decoder: takes a compressed file one byte per request
// (in_tuser marks the first header byte) and returns the decoded bytes. The
// four header bytes give a type nibble, an option (0 byte deltas, 1 16-bit
// little-endian deltas) and a little-endian size; each data byte after that
// yields one decoded byte, the last one flagged by out_tlast. A wrong type,
// a bad option or a zero size yields one status result instead. The block
// takes one byte every cycle while the output is drained; each byte passes
// through the input register, then the 8- or 9-bit add of the running sum
// into the result register. expected_type may only be written while no file
// is in flight.
module delta_filter_stream_decoder #(
  parameter int SIZE_BITS = dfsd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input request
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] file_start
  // decoded result
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // final_item
  output logic [1:0] out_tuser,  // [1:0] status
  // expected_type register
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic [3:0]          expected_type_r;
  dfsd_pkg::in_item_t  item;
  dfsd_pkg::result_t   res;
  dfsd_pkg::core_mon_t mon;
  logic                space;
  logic                fire;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_type_r <= dfsd_pkg::TYPE_RESET;
    end else if (cfg_wr_en) begin
      expected_type_r <= cfg_wr_data;
    end
  end

  // held byte is processed when the result register can take its outcome
  assign fire = item.valid && space;

  dfsd_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (space),
    .item      (item)
  );

  // header parse and running sums
  dfsd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (item),
    .expected_type (expected_type_r),
    .res           (res),
    .mon           (mon)
  );

  // result register, doubles as the skid between the two sides
  dfsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // data phase always has bytes left to decode
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mon.phase == dfsd_pkg::PH_DATA |-> !mon.left_zero)
    else $error("data phase with no bytes left");

  // status results end the file
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid && res.status != dfsd_pkg::ST_DATA |=> mon.phase == dfsd_pkg::PH_IDLE)
    else $error("status result did not return to idle");

  // last data byte closes the file
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.start && res.valid && res.status == dfsd_pkg::ST_DATA && res.last
    |=> mon.phase == dfsd_pkg::PH_DONE)
    else $error("last data byte did not close the file");

  // status results carry a zero byte and the final flag
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dfsd_pkg::ST_DATA |-> out_tdata == 8'd0 && out_tlast)
    else $error("malformed status result");

  // a held byte stays while the result register is full
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    item.valid && !space |=> item.valid)
    else $error("held byte lost under backpressure");

endmodule

// ----- rtl/core/dfsd_in_reg.sv -----
module dfsd_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  logic                advance,
  output dfsd_pkg::in_item_t  item
);

  logic       valid_r;
  logic       start_r;
  logic [7:0] data_r;

  // stage is free when empty or when its request moves on this cycle
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      start_r <= in_tuser;
      data_r  <= in_tdata;
    end
  end

  assign item.valid = valid_r;
  assign item.start = start_r;
  assign item.data  = data_r;

endmodule

// ----- rtl/core/dfsd_core.sv -----
module dfsd_core #(
  parameter int SIZE_BITS = dfsd_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  dfsd_pkg::in_item_t  item,
  input  logic [3:0]          expected_type,
  output dfsd_pkg::result_t   res,
  output dfsd_pkg::core_mon_t mon
);

  dfsd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]           hcount_r, hcount_nxt;
  logic [15:0]          shift_r, shift_nxt;
  logic                 wide_r, wide_nxt;
  logic [SIZE_BITS-1:0] left_r, left_nxt;
  logic [7:0]           sum_low_r, sum_low_nxt;
  logic [7:0]           sum_high_r, sum_high_nxt;
  logic                 carry_r, carry_nxt;
  logic                 hi_r, hi_nxt;

  logic [3:0]           opt;
  logic                 type_ok;
  logic                 opt_ok;
  logic                 hdr_last;
  logic [23:0]          size_full;
  logic [SIZE_BITS-1:0] size;
  logic                 size_zero;
  logic [8:0]           low_sum;
  logic [7:0]           high_sum;
  logic                 last_byte;

  assign opt       = item.data[3:0];
  assign type_ok   = item.data[7:4] == expected_type;
  assign opt_ok    = (opt == dfsd_pkg::OPT_NARROW) || (opt == dfsd_pkg::OPT_WIDE);
  assign hdr_last  = hcount_r == 2'd3;
  assign size_full = {item.data, shift_r};
  assign size      = size_full[SIZE_BITS-1:0];
  assign size_zero = size == '0;
  assign low_sum   = {1'b0, sum_low_r} + {1'b0, item.data};
  assign high_sum  = sum_high_r + item.data + {7'd0, carry_r};
  assign last_byte = left_r == SIZE_BITS'(1);

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (item.start) begin
        phase_nxt = (type_ok && opt_ok) ? dfsd_pkg::PH_HEADER : dfsd_pkg::PH_IDLE;
      end else begin
        unique case (phase_r)
          dfsd_pkg::PH_HEADER: begin
            if (hdr_last) begin
              phase_nxt = size_zero ? dfsd_pkg::PH_IDLE : dfsd_pkg::PH_DATA;
            end
          end
          dfsd_pkg::PH_DATA: begin
            if (last_byte) begin
              phase_nxt = dfsd_pkg::PH_DONE;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    hcount_nxt   = hcount_r;
    shift_nxt    = shift_r;
    wide_nxt     = wide_r;
    left_nxt     = left_r;
    sum_low_nxt  = sum_low_r;
    sum_high_nxt = sum_high_r;
    carry_nxt    = carry_r;
    hi_nxt       = hi_r;
    res          = '0;
    if (fire) begin
      if (item.start) begin
        hcount_nxt   = 2'd1;
        shift_nxt    = '0;
        left_nxt     = '0;
        sum_low_nxt  = '0;
        sum_high_nxt = '0;
        carry_nxt    = 1'b0;
        hi_nxt       = 1'b0;
        if (!type_ok) begin
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = dfsd_pkg::ST_TYPE;
        end else if (!opt_ok) begin
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = dfsd_pkg::ST_OPTION;
        end else begin
          wide_nxt = opt[0];
        end
      end else begin
        unique case (phase_r)
          dfsd_pkg::PH_HEADER: begin
            shift_nxt  = {item.data, shift_r[15:8]};
            hcount_nxt = hcount_r + 2'd1;
            if (hdr_last) begin
              left_nxt   = size;
              hcount_nxt = 2'd0;
              if (size_zero) begin
                res.valid  = 1'b1;
                res.last   = 1'b1;
                res.status = dfsd_pkg::ST_EMPTY;
              end
            end
          end
          dfsd_pkg::PH_DATA: begin
            res.valid  = 1'b1;
            res.last   = last_byte;
            res.status = dfsd_pkg::ST_DATA;
            left_nxt   = left_r - SIZE_BITS'(1);
            if (!wide_r) begin
              sum_low_nxt = low_sum[7:0];
              res.data    = low_sum[7:0];
            end else if (!hi_r) begin
              sum_low_nxt = low_sum[7:0];
              carry_nxt   = low_sum[8];
              hi_nxt      = 1'b1;
              res.data    = low_sum[7:0];
            end else begin
              sum_high_nxt = high_sum;
              carry_nxt    = 1'b0;
              hi_nxt       = 1'b0;
              res.data     = high_sum;
            end
          end
          default: res = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= dfsd_pkg::PH_IDLE;
      hcount_r   <= '0;
      shift_r    <= '0;
      wide_r     <= 1'b0;
      left_r     <= '0;
      sum_low_r  <= '0;
      sum_high_r <= '0;
      carry_r    <= 1'b0;
      hi_r       <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hcount_r   <= hcount_nxt;
      shift_r    <= shift_nxt;
      wide_r     <= wide_nxt;
      left_r     <= left_nxt;
      sum_low_r  <= sum_low_nxt;
      sum_high_r <= sum_high_nxt;
      carry_r    <= carry_nxt;
      hi_r       <= hi_nxt;
    end
  end

  assign mon.phase     = phase_r;
  assign mon.left_zero = left_r == '0;

endmodule

// ----- rtl/core/dfsd_out_reg.sv -----
module dfsd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  dfsd_pkg::result_t  res,
  output logic               space,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [1:0]         out_tuser
);

  logic               valid_r;
  logic [7:0]         data_r;
  logic               last_r;
  dfsd_pkg::status_t  status_r;

  assign space = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space && res.valid) begin
      data_r   <= res.data;
      last_r   <= res.last;
      status_r <= res.status;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = status_r;

endmodule

// ----- dv/delta_filter_stream_decoder_tb.sv -----
module delta_filter_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS = 2000;
  // margin for a byte's path from request to result
  localparam int SETTLE = 8;
  localparam logic [23:0] SIZE_MASK = 24'((1 << dfsd_pkg::SIZE_BITS_DEF) - 1);

  // one decoded result as the block should produce it
  typedef struct packed {
    logic [7:0]        value;
    logic              last;
    dfsd_pkg::status_t status;
  } decoded_t;

  // running-sum decoder kept alongside the block, plus the queue of
  // decoded results it is still waiting for
  class decode_scoreboard;
    logic [3:0]       type_sel;
    dfsd_pkg::phase_t phase;
    logic [2:0]       hdr_cnt;
    logic [23:0]      hdr_shift;
    logic             wide;
    logic [23:0]      left;
    logic [7:0]       acc_lo;
    logic [7:0]       acc_hi;
    logic             carry;
    logic             on_high;
    decoded_t         decoded_q[$];
    int               used;
    int               errors;

    function new();
      type_sel = dfsd_pkg::TYPE_RESET;
      phase = dfsd_pkg::PH_IDLE;
      hdr_cnt = '0;
      hdr_shift = '0;
      wide = 1'b0;
      left = '0;
      acc_lo = '0;
      acc_hi = '0;
      carry = 1'b0;
      on_high = 1'b0;
      used = 0;
      errors = 0;
    endfunction

    // accepted input request: advance the decoder and queue what it yields
    function void note_request(logic [7:0] b, logic s);
      logic [8:0] t;
      logic [7:0] val;
      if (s || phase == dfsd_pkg::PH_HEADER || phase == dfsd_pkg::PH_DATA) used++;
      if (s) begin
        // new file: drop whatever was in flight
        acc_lo = '0;
        acc_hi = '0;
        carry = 1'b0;
        on_high = 1'b0;
        hdr_shift = '0;
        hdr_cnt = 3'd1;
        left = '0;
        if (b[7:4] != type_sel) begin
          phase = dfsd_pkg::PH_IDLE;
          decoded_q.push_back('{8'h00, 1'b1, dfsd_pkg::ST_TYPE});
        end else if (b[3:0] != dfsd_pkg::OPT_NARROW && b[3:0] != dfsd_pkg::OPT_WIDE) begin
          phase = dfsd_pkg::PH_IDLE;
          decoded_q.push_back('{8'h00, 1'b1, dfsd_pkg::ST_OPTION});
        end else begin
          wide = (b[3:0] == dfsd_pkg::OPT_WIDE);
          phase = dfsd_pkg::PH_HEADER;
        end
      end else if (phase == dfsd_pkg::PH_HEADER) begin
        // size arrives little-endian
        hdr_shift = {b, hdr_shift[23:8]};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt >= 3'd4) begin
          left = hdr_shift & SIZE_MASK;
          hdr_cnt = '0;
          if (left == '0) begin
            phase = dfsd_pkg::PH_IDLE;
            decoded_q.push_back('{8'h00, 1'b1, dfsd_pkg::ST_EMPTY});
          end else begin
            phase = dfsd_pkg::PH_DATA;
          end
        end
      end else if (phase == dfsd_pkg::PH_DATA) begin
        if (!wide) begin
          acc_lo = acc_lo + b;
          val = acc_lo;
        end else if (!on_high) begin
          t = acc_lo + b;
          acc_lo = t[7:0];
          carry = t[8];
          val = acc_lo;
          on_high = 1'b1;
        end else begin
          acc_hi = acc_hi + b + carry;
          carry = 1'b0;
          val = acc_hi;
          on_high = 1'b0;
        end
        left = left - 24'd1;
        if (left == '0) phase = dfsd_pkg::PH_DONE;
        decoded_q.push_back('{val, left == '0, dfsd_pkg::ST_DATA});
      end
    endfunction

    function void check_result(logic [7:0] d, logic l, logic [1:0] st);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %0h final_item %0b status %0d", d, l, st);
        errors++;
      end else begin
        e = decoded_q.pop_front();
        if (d !== e.value) begin
          $error("out_byte expected %0h actual %0h", e.value, d);
          errors++;
        end
        if (l !== e.last) begin
          $error("final_item expected %0b actual %0b", e.last, l);
          errors++;
        end
        if (st !== e.status) begin
          $error("status expected %0d actual %0d", e.status, st);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  decode_scoreboard sb = new();
  // no idling on either side once set
  bit quiet;
  int hold_cnt;

  delta_filter_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: ready stalls in random bursts, long ready stretches between
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_cnt = $urandom_range(1, 15);
    end
    out_tready <= (hold_cnt == 0);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // one request; valid stays high between back-to-back requests so it is
  // never dropped and raised in the same step
  task automatic send_byte(input logic [7:0] b, input logic s);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(b, s);
  endtask

  // stop sending until every decoded result is back, then let the
  // pipeline settle since header bytes leave nothing to wait for
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // change expected_type with no file in flight
  task automatic write_type(input logic [3:0] v);
    // an open file is closed by a start request of the wrong type
    if (sb.phase == dfsd_pkg::PH_HEADER || sb.phase == dfsd_pkg::PH_DATA)
      send_byte({sb.type_sel ^ 4'h1, dfsd_pkg::OPT_NARROW}, 1'b1);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.type_sel = v;
    cfg_wr_en <= 1'b0;
  endtask

  // one file: mostly well formed with random content, some with a bad
  // header, a huge size cut short, an early restart or trailing noise
  task automatic send_file();
    logic [3:0]  typ;
    logic [3:0]  opt;
    logic [23:0] size;
    logic [7:0]  d;
    int          pick;
    int          n_data;
    int          cut;
    typ = ($urandom_range(0, 15) == 0) ? 4'($urandom) : sb.type_sel;
    pick = $urandom_range(0, 11);
    if (pick == 0) opt = 4'($urandom_range(2, 15));
    else if (pick < 6) opt = dfsd_pkg::OPT_NARROW;
    else opt = dfsd_pkg::OPT_WIDE;
    pick = $urandom_range(0, 19);
    if (pick == 0) size = '0;
    else if (pick == 1) size = 24'($urandom);
    else if (pick < 5) size = 24'($urandom_range(25, 200));
    else size = 24'($urandom_range(1, 24));
    // huge sizes are cut short by the next file start
    n_data = (size > 24'd200) ? $urandom_range(0, 40) : int'(size);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_data + 3) : n_data + 3;
    send_byte({typ, opt}, 1'b1);
    for (int i = 0; i < cut; i++) begin
      if (i < 3) begin
        d = size[8*i +: 8];
      end else begin
        // lean on the carry edges now and then
        pick = $urandom_range(0, 7);
        case (pick)
          0: d = 8'hFF;
          1: d = 8'h00;
          2: d = 8'h01;
          default: d = 8'($urandom);
        endcase
      end
      send_byte(d, 1'b0);
    end
    // stray bytes after the end, sometimes a random start request
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
    if ($urandom_range(0, 29) == 0) send_byte(8'($urandom), 1'b1);
    if ($urandom_range(0, 39) == 0) drain();
  endtask

  initial begin
    logic [8:0] script[$];
    logic [3:0] type_plan[5];
    // bit 8 is the start flag, low byte the data
    script = '{
      9'h0_5A,                                    // stray byte while idle
      9'h1_70,                                    // wrong type
      9'h1_8F,                                    // bad option
      9'h1_80, 9'h0_00, 9'h0_00, 9'h0_00,         // empty file
      9'h1_81, 9'h0_FF, 9'h0_FF, 9'h0_FF,         // wide, largest size
      9'h0_80, 9'h0_10, 9'h0_80, 9'h0_FF,         // low carry into high byte
      9'h1_80, 9'h0_02, 9'h0_00, 9'h0_00,         // restart mid-file, narrow
      9'h0_FF, 9'h0_01,                           // sum wraps mod 256
      9'h0_33,                                    // stray byte past the size
      9'h1_81, 9'h0_01, 9'h0_00, 9'h0_00, 9'h0_FE // wide, odd final byte
    };
    type_plan = '{dfsd_pkg::TYPE_RESET, 4'h0, 4'hF, 4'($urandom), dfsd_pkg::TYPE_RESET};

    quiet = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_byte(script[i][7:0], script[i][8]);

    // random files under each expected_type setting
    foreach (type_plan[k]) begin
      if (k > 0) write_type(type_plan[k]);
      while (sb.used < (k + 1) * ITEMS / 5) begin
        quiet <= (sb.used >= ITEMS - 200);
        send_file();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dfsd_pkg.sv
rtl/core/dfsd_in_reg.sv
rtl/core/dfsd_core.sv
rtl/core/dfsd_out_reg.sv
rtl/core/delta_filter_stream_decoder.sv
dv/delta_filter_stream_decoder_tb.sv
